### hw/rtl/ibssc_pkg.sv
package ibssc_pkg;

   // Channel state and tanh table geometry.
   localparam int CHANNELS   = 2;
   localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int TANH_DEPTH = 1024;
   localparam int IDX_W      = $clog2(TANH_DEPTH + 1);
   localparam int POS_W      = 38 + $clog2(TANH_DEPTH + 1);

   // Serial multiplier: signed operand A times unsigned operand B, one B bit a cycle.
   localparam int AW        = 36;
   localparam int BW        = 24;
   localparam int PW        = AW + BW + 1;
   localparam int CNT_W     = $clog2(BW + 1);
   localparam int MUL_STEPS = BW;

   localparam logic signed [PW-1:0] HALF16 = PW'(1) <<< 15;
   localparam logic signed [PW-1:0] HALF24 = PW'(1) <<< 23;

   typedef enum logic [2:0] {
      CSR_HP_COEFF  = 3'd0,
      CSR_LP_COEFF  = 3'd1,
      CSR_DRIVE     = 3'd2,
      CSR_DRIVE_INV = 3'd3,
      CSR_BLEND     = 3'd4,
      CSR_AMOUNT    = 3'd5
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_HP,
      ST_LP,
      ST_DRV,
      ST_TAB0,
      ST_TAB1,
      ST_TAB2,
      ST_INTERP,
      ST_INV,
      ST_BLEND,
      ST_AMT,
      ST_DONE
   } state_type;

   typedef logic [23:0] tanh_tab_type [TANH_DEPTH+1];

   localparam logic [63:0] ONE_Q31 = 64'd1 << 31;

   // Restoring division, used only while the table is built at elaboration.
   function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
      logic [63:0] q;
      logic [63:0] r;
      q = '0;
      r = '0;
      for (int i = 63; i >= 0; i--) begin
         r = {r[62:0], n[i]};
         if (r >= d) begin
            r    = r - d;
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   function automatic logic [63:0] mul_q31(input logic [63:0] a, input logic [63:0] b);
      return (a * b + (ONE_Q31 >> 1)) >> 31;
   endfunction

   // tanh in Q0.23 over [0,8], from exp(-2x) in Q31 built by repeated squaring.
   function automatic tanh_tab_type build_tanh();
      logic [63:0] pw [13];
      logic [63:0] h;
      logic [63:0] sum;
      logic [63:0] term;
      logic [63:0] den;
      logic [63:0] e;
      logic [63:0] num;
      tanh_tab_type tab;
      h    = ((64'd16 << 31) + 64'(TANH_DEPTH / 2)) / TANH_DEPTH;
      sum  = ONE_Q31;
      term = ONE_Q31;
      for (int k = 1; k <= 14; k++) begin
         den  = 64'(k) << 31;
         term = udiv64(term * h + (den >> 1), den);
         if (k % 2 == 1) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      pw[0] = sum;
      for (int k = 1; k < 13; k++) begin
         pw[k] = mul_q31(pw[k-1], pw[k-1]);
      end
      for (int i = 0; i <= TANH_DEPTH; i++) begin
         e = ONE_Q31;
         for (int k = 0; k < 13; k++) begin
            if (((i >> k) & 1) == 1) begin
               e = mul_q31(e, pw[k]);
            end
         end
         num    = (ONE_Q31 - e) << 23;
         den    = ONE_Q31 + e;
         tab[i] = 24'(udiv64(num + (den >> 1), den));
      end
      return tab;
   endfunction

   localparam tanh_tab_type TANH_TAB = build_tanh();

endpackage

### hw/rtl/input_band_shaper_soft_clip.sv
// The sequencer takes a new item only once the last one has gone to the output register;
// its pace is set by the one shared serial multiplier, which works one coefficient bit per
// cycle and reloads its operands between products, for seven products per item, or six
// when the tanh argument clamps.
// A finished result waits in the output register while the next item is taken in.
// Reset is synchronous and active high: it clears both channels' filter state, the
// sequencer and the output valid, and loads the documented register defaults.
module input_band_shaper_soft_clip (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [23:0] sample_in
   input  logic [0:0]  req_tuser,   // [0] channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [23:0] sample_out
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_data
);

   localparam int CHANNELS_L = ibssc_pkg::CHANNELS;
   localparam int AW         = ibssc_pkg::AW;
   localparam int BW         = ibssc_pkg::BW;
   localparam int PW         = ibssc_pkg::PW;

   // Configuration registers.
   logic [23:0] hp_coeff_ff;
   logic [23:0] lp_coeff_ff;
   logic [15:0] drive_ff;
   logic [23:0] drive_inv_ff;
   logic [16:0] blend_ff;
   logic [16:0] amount_ff;

   // Per-channel filter state.
   logic signed [31:0] hp_trk_ff [CHANNELS_L];
   logic signed [31:0] lp_trk_ff [CHANNELS_L];

   ibssc_pkg::state_type state_ff, state_in;

   // Item registers.
   logic signed [23:0]             x_ff;
   logic [ibssc_pkg::CH_W-1:0]     ch_ff, ch_in;
   logic signed [31:0]             band_ff;
   logic                           neg_ff;
   logic [ibssc_pkg::IDX_W-1:0]    idx_ff;
   logic [15:0]                    frac_ff;
   logic [23:0]                    y0_ff;
   logic [23:0]                    rom_q_ff;
   logic [ibssc_pkg::IDX_W-1:0]    rom_addr;
   logic signed [23:0]             result_ff;
   logic                           rsp_tvalid_ff;
   logic [23:0]                    rsp_tdata_ff;

   // Serial multiplier registers.
   logic signed [AW-1:0]           ma_ff;
   logic [BW-1:0]                  mb_ff;
   logic signed [AW:0]             mhi_ff;
   logic [BW-1:0]                  mlo_ff;
   logic [ibssc_pkg::CNT_W-1:0]    cnt_ff;
   logic signed [AW+1:0]           msum;

   // Control decoded from the state.
   logic is_mul, mul_run, mul_done, take_req, publish;

   // Results of the finished product.
   logic signed [PW-1:0]           prod, r16, r24, mag;
   logic signed [31:0]             hp_new, lp_new;
   logic                           big;
   logic [ibssc_pkg::POS_W-1:0]    pos;
   logic signed [AW-1:0]           interp_y, tval;
   logic signed [PW-1:0]           y_out;
   logic signed [23:0]             y_sat;

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // Configuration writes; unknown indexes are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         hp_coeff_ff  <= 24'd0;
         lp_coeff_ff  <= 24'hFFFFFF;
         drive_ff     <= 16'd4096;
         drive_inv_ff <= 24'd65536;
         blend_ff     <= 17'd0;
         amount_ff    <= 17'd65536;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            ibssc_pkg::CSR_HP_COEFF:  hp_coeff_ff  <= csr_data;
            ibssc_pkg::CSR_LP_COEFF:  lp_coeff_ff  <= csr_data;
            ibssc_pkg::CSR_DRIVE:     drive_ff     <= csr_data[15:0];
            ibssc_pkg::CSR_DRIVE_INV: drive_inv_ff <= csr_data;
            ibssc_pkg::CSR_BLEND:     blend_ff     <= csr_data[16:0];
            ibssc_pkg::CSR_AMOUNT:    amount_ff    <= csr_data[16:0];
            default: ;
         endcase
      end
   end

   // Product of the multiplier and the roundings that follow it.
   always_comb begin
      prod     = PW'({mhi_ff, mlo_ff});
      r16      = (prod + ibssc_pkg::HALF16) >>> 16;
      r24      = (prod + ibssc_pkg::HALF24) >>> 24;
      hp_new   = hp_trk_ff[ch_ff] + r24[31:0];
      lp_new   = lp_trk_ff[ch_ff] + r24[31:0];
      mag      = prod[PW-1] ? -prod : prod;
      big      = |mag[PW-1:38];
      pos      = ibssc_pkg::POS_W'(mag[37:0]) * ibssc_pkg::POS_W'(ibssc_pkg::TANH_DEPTH);
      interp_y = AW'($signed({1'b0, y0_ff})) + r16[AW-1:0];
      tval     = neg_ff ? -interp_y : interp_y;
      y_out    = PW'(x_ff) + r16;
      if (y_out > PW'(8388607)) begin
         y_sat = 24'sh7FFFFF;
      end else if (y_out < -PW'(8388608)) begin
         y_sat = -24'sh800000;
      end else begin
         y_sat = y_out[23:0];
      end
      if (int'(req_tuser) >= CHANNELS_L) begin
         ch_in = ibssc_pkg::CH_W'(CHANNELS_L - 1);
      end else begin
         ch_in = ibssc_pkg::CH_W'(req_tuser);
      end
      // One shift-add step: add A when the current bit of B is set.
      msum = (AW+2)'(mhi_ff) + (mb_ff[0] ? (AW+2)'(ma_ff) : '0);
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ibssc_pkg::ST_IDLE: if (req_tvalid) begin
            state_in = ibssc_pkg::ST_HP;
         end
         ibssc_pkg::ST_HP: if (cnt_ff == ibssc_pkg::CNT_W'(ibssc_pkg::MUL_STEPS)) begin
            state_in = ibssc_pkg::ST_LP;
         end
         ibssc_pkg::ST_LP: if (cnt_ff == ibssc_pkg::CNT_W'(ibssc_pkg::MUL_STEPS)) begin
            state_in = ibssc_pkg::ST_DRV;
         end
         ibssc_pkg::ST_DRV: if (cnt_ff == ibssc_pkg::CNT_W'(ibssc_pkg::MUL_STEPS)) begin
            state_in = big ? ibssc_pkg::ST_INV : ibssc_pkg::ST_TAB0;
         end
         ibssc_pkg::ST_TAB0: state_in = ibssc_pkg::ST_TAB1;
         ibssc_pkg::ST_TAB1: state_in = ibssc_pkg::ST_TAB2;
         ibssc_pkg::ST_TAB2: state_in = ibssc_pkg::ST_INTERP;
         ibssc_pkg::ST_INTERP: if (cnt_ff == ibssc_pkg::CNT_W'(ibssc_pkg::MUL_STEPS)) begin
            state_in = ibssc_pkg::ST_INV;
         end
         ibssc_pkg::ST_INV: if (cnt_ff == ibssc_pkg::CNT_W'(ibssc_pkg::MUL_STEPS)) begin
            state_in = ibssc_pkg::ST_BLEND;
         end
         ibssc_pkg::ST_BLEND: if (cnt_ff == ibssc_pkg::CNT_W'(ibssc_pkg::MUL_STEPS)) begin
            state_in = ibssc_pkg::ST_AMT;
         end
         ibssc_pkg::ST_AMT: if (cnt_ff == ibssc_pkg::CNT_W'(ibssc_pkg::MUL_STEPS)) begin
            state_in = ibssc_pkg::ST_DONE;
         end
         ibssc_pkg::ST_DONE: if (!rsp_tvalid_ff || rsp_tready) begin
            state_in = ibssc_pkg::ST_IDLE;
         end
         default: state_in = ibssc_pkg::ST_IDLE;
      endcase
   end

   // Outputs of the sequencer.
   always_comb begin
      is_mul = (state_ff == ibssc_pkg::ST_HP)     || (state_ff == ibssc_pkg::ST_LP)  ||
               (state_ff == ibssc_pkg::ST_DRV)    || (state_ff == ibssc_pkg::ST_INTERP) ||
               (state_ff == ibssc_pkg::ST_INV)    || (state_ff == ibssc_pkg::ST_BLEND) ||
               (state_ff == ibssc_pkg::ST_AMT);
      mul_done   = is_mul && (cnt_ff == ibssc_pkg::CNT_W'(ibssc_pkg::MUL_STEPS));
      mul_run    = is_mul && !mul_done;
      req_tready = (state_ff == ibssc_pkg::ST_IDLE);
      take_req   = req_tready && req_tvalid;
      publish    = (state_ff == ibssc_pkg::ST_DONE) && (!rsp_tvalid_ff || rsp_tready);
      rom_addr   = (state_ff == ibssc_pkg::ST_TAB1) ? idx_ff + ibssc_pkg::IDX_W'(1) : idx_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ibssc_pkg::ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
         cnt_ff        <= '0;
         for (int c = 0; c < CHANNELS_L; c++) begin
            hp_trk_ff[c] <= '0;
            lp_trk_ff[c] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (publish) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
         if (mul_run) begin
            cnt_ff <= cnt_ff + ibssc_pkg::CNT_W'(1);
         end else begin
            cnt_ff <= '0;
         end
         if (mul_done && state_ff == ibssc_pkg::ST_HP) begin
            hp_trk_ff[ch_ff] <= hp_new;
         end
         if (mul_done && state_ff == ibssc_pkg::ST_LP) begin
            lp_trk_ff[ch_ff] <= lp_new;
         end
      end
   end

   // Datapath: the shift-add steps and the operand loads between products.
   always_ff @(posedge clock) begin
      rom_q_ff <= ibssc_pkg::TANH_TAB[rom_addr];
      if (publish) begin
         rsp_tdata_ff <= result_ff;
      end
      if (mul_run) begin
         mhi_ff <= msum[AW+1:1];
         mlo_ff <= {msum[0], mlo_ff[BW-1:1]};
         mb_ff  <= mb_ff >> 1;
      end
      if (take_req) begin
         x_ff   <= req_tdata;
         ch_ff  <= ch_in;
         ma_ff  <= AW'($signed(req_tdata)) - AW'(hp_trk_ff[ch_in]);
         mb_ff  <= hp_coeff_ff;
         mhi_ff <= '0;
      end
      if (state_ff == ibssc_pkg::ST_TAB1) begin
         y0_ff <= rom_q_ff;
      end
      if (state_ff == ibssc_pkg::ST_TAB2) begin
         ma_ff  <= AW'($signed({1'b0, rom_q_ff})) - AW'($signed({1'b0, y0_ff}));
         mb_ff  <= BW'(frac_ff);
         mhi_ff <= '0;
      end
      if (mul_done) begin
         mhi_ff <= '0;
         unique case (state_ff)
            ibssc_pkg::ST_HP: begin
               ma_ff <= AW'(x_ff) - AW'(hp_new) - AW'(lp_trk_ff[ch_ff]);
               mb_ff <= lp_coeff_ff;
            end
            ibssc_pkg::ST_LP: begin
               band_ff <= lp_new;
               ma_ff   <= AW'(lp_new);
               mb_ff   <= BW'(drive_ff);
            end
            ibssc_pkg::ST_DRV: begin
               neg_ff  <= prod[PW-1];
               idx_ff  <= pos[38 +: ibssc_pkg::IDX_W];
               frac_ff <= pos[22 +: 16];
               // Beyond eight the clip is flat at plus or minus one.
               ma_ff   <= prod[PW-1] ? -(AW'(1) <<< 23) : (AW'(1) <<< 23);
               mb_ff   <= drive_inv_ff;
            end
            ibssc_pkg::ST_INTERP: begin
               ma_ff <= tval;
               mb_ff <= drive_inv_ff;
            end
            ibssc_pkg::ST_INV: begin
               ma_ff <= r16[AW-1:0] - AW'(band_ff);
               mb_ff <= BW'(blend_ff);
            end
            ibssc_pkg::ST_BLEND: begin
               ma_ff <= AW'(band_ff) + r16[AW-1:0] - AW'(x_ff);
               mb_ff <= BW'(amount_ff);
            end
            ibssc_pkg::ST_AMT: begin
               result_ff <= y_sat;
            end
            default: ;
         endcase
      end
   end

   // An accepted item always starts the high-pass product.
   a_start: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ibssc_pkg::ST_HP && cnt_ff == '0))
      else $error("accepted item did not start the sequence");

   // A waiting result is never overwritten.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ibssc_pkg::ST_DONE && rsp_tvalid_ff && !rsp_tready)
      |=> (state_ff == ibssc_pkg::ST_DONE))
      else $error("result left the done state while the output was full");

   // The step counter never runs past the multiplier width.
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= ibssc_pkg::CNT_W'(ibssc_pkg::MUL_STEPS))
      else $error("multiplier step counter overran");

   // The output register fills only from the done state.
   a_pub: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> ($past(state_ff) == ibssc_pkg::ST_DONE))
      else $error("output valid rose outside the done state");

endmodule
